// ----- rtl/core/shape_hit_pixel_colorizer_macros.svh -----
// Assertion helpers used by the core RTL.
`ifndef SHAPE_HIT_PIXEL_COLORIZER_MACROS_SVH
`define SHAPE_HIT_PIXEL_COLORIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shpc assertion failed");

`endif

// ----- rtl/core/shpc_pkg.sv -----
package shpc_pkg;

    localparam int MAX_SHAPES = 16;
    localparam int IDX_W      = $clog2(MAX_SHAPES);
    localparam int CNT_W      = 5;
    localparam int NUM_KINDS  = 4;
    // Walk plus the four compare stages behind the table read.
    localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(MAX_SHAPES + 4);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] KIND_SQUARE    = 2'd0;
    localparam logic [1:0] KIND_RECTANGLE = 2'd1;
    localparam logic [1:0] KIND_CIRCLE    = 2'd2;
    localparam logic [1:0] KIND_ELLIPSE   = 2'd3;

    localparam logic [1:0] REG_SQUARE_COUNT    = 2'd0;
    localparam logic [1:0] REG_RECTANGLE_COUNT = 2'd1;
    localparam logic [1:0] REG_CIRCLE_COUNT    = 2'd2;
    localparam logic [1:0] REG_ELLIPSE_COUNT   = 2'd3;

    localparam logic [7:0] FULL = 8'd255;

    typedef struct packed {
        logic              operation;
        logic [1:0]        shape_kind;
        logic [3:0]        slot;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [10:0]       extent_a;
        logic [10:0]       extent_b;
        logic [9:0]        pixel_row;
        logic [9:0]        pixel_col;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } out_t;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [10:0]        a;
    } entry3_t;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [10:0]        a;
        logic [10:0]        b;
    } entry4_t;

    localparam int E3_W = $bits(entry3_t);
    localparam int E4_W = $bits(entry4_t);

endpackage

// ----- rtl/core/shpc_ram.sv -----
module shpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/shape_hit_pixel_colorizer.sv -----
// Shape hit pixel colorizer.
// Input channel s_valid/s_ready/s_data carries one item per transfer: a
// shape write (stored at the given slot of that kind's table) or a pixel
// query. Each query gives one color on m_valid/m_ready/m_data; writes give
// nothing. Registers (active entry count per kind) must be written through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not check it.
// A write leaves s_ready high after it. A query walks the four tables side
// by side, one slot per cycle over all 16 slots, through one synchronous
// read port per table and four compare stages; the result is then loaded
// into the output register. s_ready stays low from the query transfer
// until that load, so the next item is taken only after it.
// Color priority: ellipse magenta, circle blue, rectangle green, square
// red, else black.
// Reset (aresetn low, synchronous) clears the counts, the sequencer and the
// output valid; table contents stay undefined until written.
// While the receiver stalls, the finished color holds in the output
// register and a new item is still accepted; the next query's result waits
// until that color is taken.
`include "shape_hit_pixel_colorizer_macros.svh"

module shape_hit_pixel_colorizer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  shpc_pkg::in_t        s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output shpc_pkg::out_t       m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    function automatic logic [11:0] abs_diff(input logic signed [11:0] c,
                                             input logic [9:0] p);
        logic signed [13:0] d;
        begin
            d = 14'(c) - $signed({4'b0, p});
            abs_diff = d[13] ? 12'(-d) : 12'(d);
        end
    endfunction

    function automatic logic box_hit(input logic signed [11:0] x,
                                     input logic signed [11:0] y,
                                     input logic [10:0] w,
                                     input logic [10:0] h,
                                     input logic [9:0] i,
                                     input logic [9:0] j);
        logic signed [13:0] si, sj, sx, sy, ex, ey;
        begin
            si = $signed({4'b0, i});
            sj = $signed({4'b0, j});
            sx = 14'(x);
            sy = 14'(y);
            ex = sx + $signed({3'b0, w});
            ey = sy + $signed({3'b0, h});
            box_hit = (si >= sy) && (si <= ey) && (sj >= sx) && (sj <= ex);
        end
    endfunction

    state_t state_reg, state_next;
    logic [shpc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [shpc_pkg::CNT_W-1:0] count_reg [shpc_pkg::NUM_KINDS];
    logic [9:0] row_reg, col_reg;
    logic [3:0] hit_reg, hit_next;
    shpc_pkg::out_t out_reg, out_next;
    logic m_valid_reg;

    logic s_xfer, m_xfer, load_out;
    logic [shpc_pkg::IDX_W-1:0] raddr;
    logic [3:0] issue_v;
    logic [3:0] we;

    shpc_pkg::entry3_t sq_rd, ci_rd;
    shpc_pkg::entry4_t re_rd, el_rd;
    shpc_pkg::entry3_t w3;
    shpc_pkg::entry4_t w4;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid_reg && m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign raddr   = cnt_reg[shpc_pkg::IDX_W-1:0];

    assign w3 = '{x: s_data.pos_x, y: s_data.pos_y, a: s_data.extent_a};
    assign w4 = '{x: s_data.pos_x, y: s_data.pos_y, a: s_data.extent_a,
                  b: s_data.extent_b};

    always_comb begin
        we = '0;
        if (s_xfer && s_data.operation == shpc_pkg::OP_WRITE) begin
            case (s_data.shape_kind)
                shpc_pkg::KIND_SQUARE:    we[0] = 1'b1;
                shpc_pkg::KIND_RECTANGLE: we[1] = 1'b1;
                shpc_pkg::KIND_CIRCLE:    we[2] = 1'b1;
                shpc_pkg::KIND_ELLIPSE:   we[3] = 1'b1;
                default:                  we    = '0;
            endcase
        end
    end

    shpc_ram #(.WIDTH(shpc_pkg::E3_W), .DEPTH(shpc_pkg::MAX_SHAPES)) u_square (
        .aclk(aclk), .we(we[0]), .waddr(s_data.slot), .wdata(w3),
        .raddr(raddr), .rdata(sq_rd)
    );
    shpc_ram #(.WIDTH(shpc_pkg::E4_W), .DEPTH(shpc_pkg::MAX_SHAPES)) u_rectangle (
        .aclk(aclk), .we(we[1]), .waddr(s_data.slot), .wdata(w4),
        .raddr(raddr), .rdata(re_rd)
    );
    shpc_ram #(.WIDTH(shpc_pkg::E3_W), .DEPTH(shpc_pkg::MAX_SHAPES)) u_circle (
        .aclk(aclk), .we(we[2]), .waddr(s_data.slot), .wdata(w3),
        .raddr(raddr), .rdata(ci_rd)
    );
    shpc_ram #(.WIDTH(shpc_pkg::E4_W), .DEPTH(shpc_pkg::MAX_SHAPES)) u_ellipse (
        .aclk(aclk), .we(we[3]), .waddr(s_data.slot), .wdata(w4),
        .raddr(raddr), .rdata(el_rd)
    );

    // Slot is live in the walk when below both 16 and that kind's count.
    always_comb begin
        for (int k = 0; k < shpc_pkg::NUM_KINDS; k++) begin
            issue_v[k] = (state_reg == ST_WALK)
                      && (cnt_reg < shpc_pkg::CNT_W'(shpc_pkg::MAX_SHAPES))
                      && (cnt_reg < count_reg[k]);
        end
    end

    // Compare pipeline: v1 read data, v2 distances, v3 squares, v4 products.
    logic [3:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic sq2_reg, re2_reg, sq3_reg, re3_reg, sq4_reg, re4_reg;
    logic [11:0] cdx2_reg, cdy2_reg, edx2_reg, edy2_reg;
    logic [10:0] ca2_reg, ea2_reg, eb2_reg;
    logic [23:0] cdx3_reg, cdy3_reg, edx3_reg, edy3_reg;
    logic [21:0] ca3_reg, ea3_reg, eb3_reg;
    logic ci4_reg, enz3_reg, enz4_reg;
    logic [45:0] p1_reg, p2_reg;
    logic [43:0] p3_reg;
    logic el_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= '0;
            v2_reg <= '0;
            v3_reg <= '0;
            v4_reg <= '0;
        end else begin
            v1_reg <= issue_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sq2_reg  <= box_hit(sq_rd.x, sq_rd.y, sq_rd.a, sq_rd.a, row_reg, col_reg);
        re2_reg  <= box_hit(re_rd.x, re_rd.y, re_rd.a, re_rd.b, row_reg, col_reg);
        cdx2_reg <= abs_diff(ci_rd.x, col_reg);
        cdy2_reg <= abs_diff(ci_rd.y, row_reg);
        ca2_reg  <= ci_rd.a;
        edx2_reg <= abs_diff(el_rd.x, col_reg);
        edy2_reg <= abs_diff(el_rd.y, row_reg);
        ea2_reg  <= el_rd.a;
        eb2_reg  <= el_rd.b;

        sq3_reg  <= sq2_reg;
        re3_reg  <= re2_reg;
        cdx3_reg <= cdx2_reg * cdx2_reg;
        cdy3_reg <= cdy2_reg * cdy2_reg;
        ca3_reg  <= ca2_reg * ca2_reg;
        edx3_reg <= edx2_reg * edx2_reg;
        edy3_reg <= edy2_reg * edy2_reg;
        ea3_reg  <= ea2_reg * ea2_reg;
        eb3_reg  <= eb2_reg * eb2_reg;
        enz3_reg <= (ea2_reg != '0) && (eb2_reg != '0);

        sq4_reg  <= sq3_reg;
        re4_reg  <= re3_reg;
        ci4_reg  <= (25'(cdx3_reg) + 25'(cdy3_reg)) <= 25'(ca3_reg);
        p1_reg   <= 46'(edx3_reg) * 46'(eb3_reg);
        p2_reg   <= 46'(edy3_reg) * 46'(ea3_reg);
        p3_reg   <= 44'(ea3_reg) * 44'(eb3_reg);
        enz4_reg <= enz3_reg;
    end

    assign el_hit = enz4_reg && ((47'(p1_reg) + 47'(p2_reg)) <= 47'(p3_reg));

    always_comb begin
        hit_next = hit_reg;
        if (s_xfer) begin
            hit_next = '0;
        end else begin
            hit_next[0] = hit_reg[0] | (v4_reg[0] & sq4_reg);
            hit_next[1] = hit_reg[1] | (v4_reg[1] & re4_reg);
            hit_next[2] = hit_reg[2] | (v4_reg[2] & ci4_reg);
            hit_next[3] = hit_reg[3] | (v4_reg[3] & el_hit);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_data.operation == shpc_pkg::OP_QUERY) begin
                    state_next = ST_WALK;
                    cnt_next   = '0;
                end
            end
            ST_WALK: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == shpc_pkg::WALK_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the color until the output slot is free
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_next = '0;
        if (hit_reg[3]) begin
            out_next.red  = shpc_pkg::FULL;
            out_next.blue = shpc_pkg::FULL;
        end else if (hit_reg[2]) begin
            out_next.blue = shpc_pkg::FULL;
        end else if (hit_reg[1]) begin
            out_next.green = shpc_pkg::FULL;
        end else if (hit_reg[0]) begin
            out_next.red = shpc_pkg::FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            hit_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < shpc_pkg::NUM_KINDS; k++) begin
                count_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_xfer) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    shpc_pkg::REG_SQUARE_COUNT:    count_reg[0] <= cfg_wdata;
                    shpc_pkg::REG_RECTANGLE_COUNT: count_reg[1] <= cfg_wdata;
                    shpc_pkg::REG_CIRCLE_COUNT:    count_reg[2] <= cfg_wdata;
                    shpc_pkg::REG_ELLIPSE_COUNT:   count_reg[3] <= cfg_wdata;
                    default:                       count_reg[0] <= count_reg[0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            row_reg <= s_data.pixel_row;
            col_reg <= s_data.pixel_col;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    `SHPC_ASSERT_NOW(a_valid_from_done, aclk, aresetn,
        $rose(m_valid_reg), $past(state_reg == ST_DONE))
    `SHPC_ASSERT_NEXT(a_walk_holds, aclk, aresetn,
        state_reg == ST_WALK && cnt_reg != shpc_pkg::WALK_LAST, state_reg == ST_WALK)
    `SHPC_ASSERT_NOW(a_pipe_empty_idle, aclk, aresetn,
        state_reg == ST_IDLE, v4_reg == '0 && v1_reg == '0)
    `SHPC_ASSERT_NOW(a_one_color, aclk, aresetn,
        m_valid_reg, $countones({out_reg.red != '0, out_reg.green != '0}) <= 1)

endmodule

// ----- dv/shape_hit_pixel_colorizer_test.sv -----
module shape_hit_pixel_colorizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 870;
    localparam int CHUNKS     = 6;
    localparam int SETTLE     = 30;
    localparam int IN_W       = $bits(shpc_pkg::in_t);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    shpc_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    shpc_pkg::out_t m_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = shpc_pkg::REG_SQUARE_COUNT;
    logic [4:0] cfg_wdata = '0;

    shape_hit_pixel_colorizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow of the shape tables and active counts.
    shpc_pkg::entry4_t sq_tab[shpc_pkg::MAX_SHAPES];
    shpc_pkg::entry4_t rect_tab[shpc_pkg::MAX_SHAPES];
    shpc_pkg::entry4_t ci_tab[shpc_pkg::MAX_SHAPES];
    shpc_pkg::entry4_t el_tab[shpc_pkg::MAX_SHAPES];
    logic [4:0] shape_cnt[shpc_pkg::NUM_KINDS];

    shpc_pkg::out_t color_q[$];
    int   fails = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    bit   hold_go = 1'b0;
    int   hold_cnt = 0;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef struct {
        row_kind_t      kind;
        shpc_pkg::in_t  item;
        logic [1:0]     reg_idx;
        logic [4:0]     reg_val;
        bit             known;
        shpc_pkg::out_t want;
    } step_t;

    localparam shpc_pkg::out_t BLACK   = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam shpc_pkg::out_t RED     = '{red: shpc_pkg::FULL, green: 8'd0, blue: 8'd0};
    localparam shpc_pkg::out_t GREEN   = '{red: 8'd0, green: shpc_pkg::FULL, blue: 8'd0};
    localparam shpc_pkg::out_t BLUE    = '{red: 8'd0, green: 8'd0, blue: shpc_pkg::FULL};
    localparam shpc_pkg::out_t MAGENTA = '{red: shpc_pkg::FULL, green: 8'd0,
                                           blue: shpc_pkg::FULL};

    function automatic int active_cnt(logic [4:0] c);
        return (c > shpc_pkg::MAX_SHAPES) ? shpc_pkg::MAX_SHAPES : int'(c);
    endfunction

    function automatic void store_shape(shpc_pkg::in_t it);
        shpc_pkg::entry4_t e;
        e.x = it.pos_x;
        e.y = it.pos_y;
        e.a = it.extent_a;
        e.b = it.extent_b;
        case (it.shape_kind)
            shpc_pkg::KIND_SQUARE:    begin e.b = '0; sq_tab[it.slot] = e; end
            shpc_pkg::KIND_RECTANGLE: rect_tab[it.slot] = e;
            shpc_pkg::KIND_CIRCLE:    begin e.b = '0; ci_tab[it.slot] = e; end
            default:                  el_tab[it.slot] = e;
        endcase
    endfunction

    function automatic bit in_box(shpc_pkg::entry4_t e, longint w, longint h,
                                  longint i, longint j);
        longint x, y;
        x = longint'($signed(e.x));
        y = longint'($signed(e.y));
        return i >= y && i <= y + h && j >= x && j <= x + w;
    endfunction

    function automatic shpc_pkg::out_t paint_pixel(shpc_pkg::in_t q);
        longint i, j, dx, dy, a, b;
        bit hs, hr, hc, he;
        shpc_pkg::out_t c;
        i = longint'(q.pixel_row);
        j = longint'(q.pixel_col);
        hs = 0; hr = 0; hc = 0; he = 0;
        for (int k = 0; k < active_cnt(shape_cnt[shpc_pkg::KIND_SQUARE]); k++)
            if (in_box(sq_tab[k], longint'(sq_tab[k].a), longint'(sq_tab[k].a), i, j))
                hs = 1;
        for (int k = 0; k < active_cnt(shape_cnt[shpc_pkg::KIND_RECTANGLE]); k++)
            if (in_box(rect_tab[k], longint'(rect_tab[k].a), longint'(rect_tab[k].b), i, j))
                hr = 1;
        for (int k = 0; k < active_cnt(shape_cnt[shpc_pkg::KIND_CIRCLE]); k++) begin
            dx = longint'($signed(ci_tab[k].x)) - j;
            dy = longint'($signed(ci_tab[k].y)) - i;
            a = longint'(ci_tab[k].a);
            if (dx * dx + dy * dy <= a * a) hc = 1;
        end
        for (int k = 0; k < active_cnt(shape_cnt[shpc_pkg::KIND_ELLIPSE]); k++) begin
            dx = longint'($signed(el_tab[k].x)) - j;
            dy = longint'($signed(el_tab[k].y)) - i;
            a = longint'(el_tab[k].a);
            b = longint'(el_tab[k].b);
            // zero radius never hits
            if (a != 0 && b != 0 && dx * dx * b * b + dy * dy * a * a <= a * a * b * b)
                he = 1;
        end
        if (he) c = MAGENTA;
        else if (hc) c = BLUE;
        else if (hr) c = GREEN;
        else if (hs) c = RED;
        else c = BLACK;
        return c;
    endfunction

    function automatic shpc_pkg::in_t shape_item(logic [1:0] kind, logic [3:0] slot,
                                                 int x, int y, int a, int b);
        shpc_pkg::in_t it;
        it = '0;
        it.operation = shpc_pkg::OP_WRITE;
        it.shape_kind = kind;
        it.slot = slot;
        it.pos_x = 12'(x);
        it.pos_y = 12'(y);
        it.extent_a = 11'(a);
        it.extent_b = 11'(b);
        return it;
    endfunction

    function automatic shpc_pkg::in_t pixel_item(int row, int col);
        shpc_pkg::in_t it;
        it = '0;
        it.operation = shpc_pkg::OP_QUERY;
        it.pixel_row = 10'(row);
        it.pixel_col = 10'(col);
        return it;
    endfunction

    function automatic int rand_pos();
        if ($urandom_range(99) < 80) return int'($urandom_range(1200)) - 100;
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic int rand_ext();
        if ($urandom_range(99) < 80) return int'($urandom_range(300));
        return int'($urandom_range(2047));
    endfunction

    function automatic shpc_pkg::in_t rand_shape(logic [1:0] kind, logic [3:0] slot);
        shpc_pkg::in_t it;
        it = shape_item(kind, slot, rand_pos(), rand_pos(), rand_ext(), rand_ext());
        // unused pixel fields carry noise
        it.pixel_row = 10'($urandom);
        it.pixel_col = 10'($urandom);
        return it;
    endfunction

    function automatic shpc_pkg::in_t rand_item();
        shpc_pkg::in_t it;
        if ($urandom_range(99) < 30)
            return rand_shape(2'($urandom), 4'($urandom));
        it = shpc_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
        it.operation = shpc_pkg::OP_QUERY;
        return it;
    endfunction

    task automatic send_item(shpc_pkg::in_t it, bit known, shpc_pkg::out_t want);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.operation == shpc_pkg::OP_WRITE) begin
            store_shape(it);
        end else begin
            color_q.push_back(paint_pixel(it));
            if (known && paint_pixel(it) != want) begin
                $display("%0t: directed color expected %h actual %h",
                         $time, want, paint_pixel(it));
                fails++;
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (color_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_count(logic [1:0] idx, logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shape_cnt[idx] = val;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            m_ready <= 1'b0;
            hold_cnt--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        shpc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (color_q.size() == 0) begin
                $display("%0t: unexpected color %h", $time, m_data);
                fails++;
            end else begin
                want = color_q.pop_front();
                if (m_data.red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, m_data.red);
                    fails++;
                end
                if (m_data.green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d",
                             $time, want.green, m_data.green);
                    fails++;
                end
                if (m_data.blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d",
                             $time, want.blue, m_data.blue);
                    fails++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        step_t steps[$];
        step_t st;
        int per_chunk;
        logic [4:0] picks[3];

        for (int k = 0; k < shpc_pkg::NUM_KINDS; k++) shape_cnt[k] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every slot so that any count only reads written entries.
        for (int k = 0; k < shpc_pkg::NUM_KINDS; k++)
            for (int s = 0; s < shpc_pkg::MAX_SHAPES; s++)
                send_item(rand_shape(2'(k), 4'(s)), 1'b0, BLACK);

        st = '{ROW_ITEM, '0, shpc_pkg::REG_SQUARE_COUNT, '0, 1'b1, BLACK};
        st.item = pixel_item(0, 0);                          steps.push_back(st);
        st.item = pixel_item(1023, 1023);                    steps.push_back(st);
        st.known = 1'b0;
        st.item = shape_item(shpc_pkg::KIND_SQUARE, 0, 0, 0, 10, 2047);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_RECTANGLE, 0, 100, 50, 20, 5);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_CIRCLE, 0, 500, 500, 10, 0);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_ELLIPSE, 0, 800, 300, 40, 20);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_CIRCLE, 1, 800, 300, 5, 0);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_ELLIPSE, 1, 500, 500, 0, 100);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_SQUARE, 15, 2047, -2048, 2047, 0);
        steps.push_back(st);
        st.item = shape_item(shpc_pkg::KIND_ELLIPSE, 15, -2048, 2047, 2047, 0);
        steps.push_back(st);
        st.kind = ROW_CFG;
        st.reg_idx = shpc_pkg::REG_SQUARE_COUNT;    st.reg_val = 5'd1; steps.push_back(st);
        st.reg_idx = shpc_pkg::REG_RECTANGLE_COUNT; st.reg_val = 5'd1; steps.push_back(st);
        st.reg_idx = shpc_pkg::REG_CIRCLE_COUNT;    st.reg_val = 5'd2; steps.push_back(st);
        st.reg_idx = shpc_pkg::REG_ELLIPSE_COUNT;   st.reg_val = 5'd2; steps.push_back(st);
        st.kind = ROW_ITEM;
        st.known = 1'b1;
        st.want = RED;     st.item = pixel_item(10, 10);   steps.push_back(st);
        st.want = BLACK;   st.item = pixel_item(11, 10);   steps.push_back(st);
        st.want = GREEN;   st.item = pixel_item(55, 120);  steps.push_back(st);
        st.want = BLACK;   st.item = pixel_item(56, 120);  steps.push_back(st);
        st.want = BLUE;    st.item = pixel_item(500, 500); steps.push_back(st);
        st.want = MAGENTA; st.item = pixel_item(300, 800); steps.push_back(st);
        st.want = MAGENTA; st.item = pixel_item(300, 840); steps.push_back(st);
        st.want = BLACK;   st.item = pixel_item(300, 841); steps.push_back(st);
        st.kind = ROW_CFG; st.known = 1'b0;
        st.reg_idx = shpc_pkg::REG_ELLIPSE_COUNT;   st.reg_val = 5'd31; steps.push_back(st);
        st.kind = ROW_ITEM;
        st.item = pixel_item(1023, 0);  steps.push_back(st);
        st.item = pixel_item(0, 1023);  steps.push_back(st);

        foreach (steps[n]) begin
            if (steps[n].kind == ROW_CFG) begin
                wait_idle();
                set_count(steps[n].reg_idx, steps[n].reg_val);
            end else begin
                send_item(steps[n].item, steps[n].known, steps[n].want);
            end
        end

        picks = '{5'd0, 5'd16, 5'd31};
        per_chunk = RAND_ITEMS / CHUNKS;
        for (int c = 0; c < CHUNKS; c++) begin
            wait_idle();
            for (int k = 0; k < shpc_pkg::NUM_KINDS; k++)
                set_count(2'(k), (c == 0) ? 5'd16 :
                          ($urandom_range(99) < 40) ? picks[$urandom_range(2)]
                                                    : 5'($urandom));
            case (c / 2)
                0:       begin send_idle = 25; recv_idle = 51; end
                1:       begin send_idle = 51; recv_idle = 25; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            for (int n = 0; n < per_chunk; n++) begin
                // long receiver stall while input keeps coming
                if (c == 4 && n == 10) hold_go = 1'b1;
                send_item(rand_item(), 1'b0, BLACK);
            end
        end

        s_valid <= 1'b0;
        while (color_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
